// ===== rtl/core/fat_cluster_chain_table_core_assert.svh =====
// Assertion macros for the cluster chain table core checker.
// Needs nothing but the including module's clock and reset.
`ifndef FAT_CLUSTER_CHAIN_TABLE_CORE_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_TABLE_CORE_ASSERT_SVH

// Check a property while out of reset.
`define FCCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, in reset too.
`define FCCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fcct_pkg.sv =====
// Types and constants of the cluster chain table core.
// Used by the link RAM, the top level and the checker.
package fcct_pkg;

  localparam int unsigned TABLE_ENTRIES = 65536;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned LINK_W        = 28;
  localparam int unsigned LIMIT_W       = 17;
  localparam int unsigned COUNT_W       = 17;

  localparam logic [LINK_W-1:0]  END_OF_CHAIN = 28'hFFFFFF8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 17'h10000;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX    = LIMIT_W'(TABLE_ENTRIES);
  localparam logic [LIMIT_W-1:0] SCAN_FIRST   = 17'd2;
  localparam logic [IDX_W-1:0]   CLEAR_LAST   = {IDX_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_CHK,
    S_FREE_RD,
    S_HOLD
  } state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== rtl/core/fat_cluster_chain_table_core.sv =====
// Top level of the cluster chain table: sequencer around the link RAM.
// Depends on fcct_pkg and fcct_ram.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid_i/in_stall_o  | req_type_i, cluster_i, next_value_i
//   out      | out_valid_o/out_stall_i| value_o, status_o, freed_count_o
//   cfg      | cfg_we_i               | cfg_wdata_i
//
// Read: waits for the registered RAM data; write or read range error: done on
// acceptance; allocate: one read per entry scanned; free: one per entry zeroed.
// One RAM read port sets the pace.
// After reset a clearing pass zeroes the table, stall high.
// A finished result waits in a hold register while the output is stalled.
module fat_cluster_chain_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fcct_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [fcct_pkg::LINK_W-1:0]   cluster_i,
  input  logic [fcct_pkg::LINK_W-1:0]   next_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fcct_pkg::LINK_W-1:0]   value_o,
  output logic [1:0]                    status_o,
  output logic [fcct_pkg::COUNT_W-1:0]  freed_count_o
);
  import fcct_pkg::*;

  state_e             state_q, state_d;
  logic [LIMIT_W-1:0] limit_q;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [LIMIT_W-1:0] scan_q, scan_d;
  logic [LINK_W-1:0]  c_q, c_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [LINK_W-1:0]  value_q, hold_value_q;
  logic [1:0]         status_q, hold_status_q;
  logic [COUNT_W-1:0] count_q, hold_count_q;

  ram_wr_t            wr;
  ram_rd_t            rd;
  logic [LINK_W-1:0]  rdata;
  logic               fin;
  logic [LINK_W-1:0]  res_value;
  status_e            res_status;
  logic [COUNT_W-1:0] res_count;

  logic               in_acc, out_free, in_inr, scan_lt, c_end, c_range;
  logic [LIMIT_W-1:0] limit;
  req_e               req;

  assign req      = req_e'(req_type_i);
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_inr   = (cluster_i[LINK_W-1:IDX_W] == '0);
  assign limit    = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
  assign scan_lt  = (scan_q < limit);
  assign c_end    = (c_q == '0) || (c_q >= END_OF_CHAIN);
  assign c_range  = (c_q[LINK_W-1:IDX_W] != '0);

  fcct_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == CLEAR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_READ:  state_d = in_inr ? S_READ : (out_free ? S_IDLE : S_HOLD);
            REQ_WRITE: state_d = out_free ? S_IDLE : S_HOLD;
            REQ_ALLOC: state_d = S_ALLOC_RD;
            REQ_FREE:  state_d = S_FREE_CHK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_READ:      state_d = out_free ? S_IDLE : S_HOLD;
      S_ALLOC_RD:  state_d = scan_lt ? S_ALLOC_CHK : (out_free ? S_IDLE : S_HOLD);
      S_ALLOC_CHK: state_d = fin ? (out_free ? S_IDLE : S_HOLD) : S_ALLOC_RD;
      S_FREE_CHK:  state_d = fin ? (out_free ? S_IDLE : S_HOLD) : S_FREE_RD;
      S_FREE_RD:   state_d = S_FREE_CHK;
      S_HOLD:      state_d = out_free ? S_IDLE : S_HOLD;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    wr         = '0;
    rd         = '0;
    fin        = 1'b0;
    res_value  = '0;
    res_status = STAT_OK;
    res_count  = '0;
    clr_d      = clr_q;
    scan_d     = scan_q;
    c_d        = c_q;
    cnt_d      = cnt_q;
    case (state_q)
      S_CLEAR: begin
        wr    = '{we: 1'b1, addr: clr_q, data: '0};
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        rd = '{re: in_acc && (req == REQ_READ) && in_inr, addr: cluster_i[IDX_W-1:0]};
        if (in_acc) begin
          case (req)
            REQ_READ: begin
              if (!in_inr) begin
                fin        = 1'b1;
                res_status = STAT_RANGE;
              end
            end
            REQ_WRITE: begin
              fin = 1'b1;
              if (in_inr) begin
                wr = '{we: 1'b1, addr: cluster_i[IDX_W-1:0], data: next_value_i};
              end else begin
                res_status = STAT_RANGE;
              end
            end
            REQ_ALLOC: scan_d = SCAN_FIRST;
            REQ_FREE: begin
              c_d   = cluster_i;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        fin       = 1'b1;
        res_value = rdata;
      end
      S_ALLOC_RD: begin
        if (scan_lt) begin
          rd = '{re: 1'b1, addr: scan_q[IDX_W-1:0]};
        end else begin
          fin        = 1'b1;
          res_status = STAT_NO_FREE;
        end
      end
      S_ALLOC_CHK: begin
        if (rdata == '0) begin
          wr        = '{we: 1'b1, addr: scan_q[IDX_W-1:0], data: END_OF_CHAIN};
          fin       = 1'b1;
          res_value = LINK_W'(scan_q);
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_FREE_CHK: begin
        res_count = cnt_q;
        if (c_end) begin
          fin = 1'b1;
        end else if (c_range) begin
          fin        = 1'b1;
          res_status = STAT_RANGE;
        end else begin
          rd = '{re: 1'b1, addr: c_q[IDX_W-1:0]};
        end
      end
      S_FREE_RD: begin
        wr    = '{we: 1'b1, addr: c_q[IDX_W-1:0], data: '0};
        c_d   = rdata;
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || ((fin || state_q == S_HOLD) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      limit_q     <= LIMIT_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    c_q    <= c_d;
    cnt_q  <= cnt_d;
    if (fin && !out_free) begin
      hold_value_q  <= res_value;
      hold_status_q <= res_status;
      hold_count_q  <= res_count;
    end
    if (fin && out_free) begin
      value_q  <= res_value;
      status_q <= res_status;
      count_q  <= res_count;
    end else if (state_q == S_HOLD && out_free) begin
      value_q  <= hold_value_q;
      status_q <= hold_status_q;
      count_q  <= hold_count_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign status_o      = status_q;
  assign freed_count_o = count_q;

endmodule

// ===== rtl/core/fcct_ram.sv =====
// Link table storage: one write port, one read port, registered read data.
// Depends on fcct_pkg for the port structs and sizes.
module fcct_ram (
  input  logic                      clk_i,
  input  fcct_pkg::ram_wr_t         wr_i,
  input  fcct_pkg::ram_rd_t         rd_i,
  output logic [fcct_pkg::LINK_W-1:0] rdata_o
);
  import fcct_pkg::*;

  logic [LINK_W-1:0] mem [TABLE_ENTRIES];
  logic [LINK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fcct_checker.sv =====
// Port-level checker for the cluster chain table core, bound to the top.
// Depends on fcct_pkg and fat_cluster_chain_table_core_assert.svh.
`include "fat_cluster_chain_table_core_assert.svh"

module fcct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [fcct_pkg::LINK_W-1:0]  value_o,
  input logic [1:0]                   status_o,
  input logic [fcct_pkg::COUNT_W-1:0] freed_count_o
);
  import fcct_pkg::*;

  `FCCT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o) && $stable(freed_count_o), "stalled result changed")
  `FCCT_ASSERT(a_nofree_zero, clk_i, rst_ni, out_valid_o && status_o == STAT_NO_FREE |-> value_o == '0 && freed_count_o == '0, "no-free result not zero")
  `FCCT_ASSERT(a_range_zero, clk_i, rst_ni, out_valid_o && status_o == STAT_RANGE |-> value_o == '0, "range error carries a value")
  `FCCT_ASSERT(a_count_no_value, clk_i, rst_ni, out_valid_o && freed_count_o != '0 |-> value_o == '0 && status_o != STAT_NO_FREE, "freed count with value")
  `FCCT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> in_stall_o && !out_valid_o, "busy or valid in reset")

endmodule

bind fat_cluster_chain_table_core fcct_checker u_fcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .value_o       (value_o),
  .status_o      (status_o),
  .freed_count_o (freed_count_o)
);
